@@ hdl/tfn_pkg.sv @@
package tfn_pkg;

	// input and output field widths
	localparam int COORD_BITS       = 16;
	localparam int NORMAL_FRAC_BITS = 14;
	localparam int OUT_W            = 16;

	// exact edge, product and cross widths
	localparam int EDGE_W  = COORD_BITS + 1;
	localparam int PROD_W  = 2 * EDGE_W;
	localparam int CROSS_W = 2 * COORD_BITS + 3;
	localparam int MAG_W   = 2 * COORD_BITS + 2;

	// block scaling keeps each magnitude below 2^31
	localparam int SCALE_W   = 31;
	localparam int SHIFT_MAX = (MAG_W > SCALE_W) ? (MAG_W - SCALE_W) : 0;
	localparam int SHIFT_W   = (SHIFT_MAX > 0) ? $clog2(SHIFT_MAX + 1) : 1;

	// sum of squares and its root
	localparam int SUM_W      = 2 * SCALE_W + 2;
	localparam int ROOT_W     = SUM_W / 2;
	localparam int REM_W      = ROOT_W + 3;
	localparam int SQRT_STEPS = 2;
	localparam int SQRT_STGS  = ROOT_W / SQRT_STEPS;

	// quotient with one extra bit for rounding
	localparam int Q2_W      = NORMAL_FRAC_BITS + 2;
	localparam int DREM_W    = ROOT_W + 1;
	localparam int DIV_STEPS = 4;
	localparam int DIV_STGS  = (Q2_W + DIV_STEPS - 1) / DIV_STEPS;
	localparam int NORM_LIM  = ((1 << NORMAL_FRAC_BITS) > 32767) ? 32767
		: (1 << NORMAL_FRAC_BITS);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [OUT_W-1:0]      norm_t;

	typedef struct packed {
		coord_t v0_x;
		coord_t v0_y;
		coord_t v0_z;
		coord_t v1_x;
		coord_t v1_y;
		coord_t v1_z;
		coord_t v2_x;
		coord_t v2_y;
		coord_t v2_z;
	} face_t;

	typedef struct packed {
		logic signed [CROSS_W-1:0] cx;
		logic signed [CROSS_W-1:0] cy;
		logic signed [CROSS_W-1:0] cz;
	} cross_t;

	typedef struct packed {
		logic               neg;
		logic [SCALE_W-1:0] mag;
	} lane_t;

	typedef struct packed {
		lane_t [2:0] lane;
		logic        degen;
	} scaled_t;

	typedef struct packed {
		scaled_t          s;
		logic [SUM_W-1:0] sum;
	} sq_t;

	typedef struct packed {
		scaled_t           s;
		logic [ROOT_W-1:0] len;
	} len_t;

	typedef struct packed {
		norm_t normal_x;
		norm_t normal_y;
		norm_t normal_z;
		logic  degenerate;
	} normal_t;

endpackage

@@ hdl/tfn_face_if.sv @@
interface tfn_face_if;
	import tfn_pkg::*;

	logic   valid;
	logic   ready;
	coord_t v0_x;
	coord_t v0_y;
	coord_t v0_z;
	coord_t v1_x;
	coord_t v1_y;
	coord_t v1_z;
	coord_t v2_x;
	coord_t v2_y;
	coord_t v2_z;

	modport source (
		output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
		input  ready
	);
	modport sink (
		input  valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
		output ready
	);
endinterface

@@ hdl/tfn_normal_if.sv @@
interface tfn_normal_if;
	import tfn_pkg::*;

	logic  valid;
	logic  ready;
	norm_t normal_x;
	norm_t normal_y;
	norm_t normal_z;
	logic  degenerate;

	modport source (
		output valid, normal_x, normal_y, normal_z, degenerate,
		input  ready
	);
	modport sink (
		input  valid, normal_x, normal_y, normal_z, degenerate,
		output ready
	);
endinterface

@@ hdl/triangle_face_normal_top.sv @@
// channel   direction  payload
// face      in         v0_x v0_y v0_z v1_x v1_y v1_z v2_x v2_y v2_z
// result    out        normal_x normal_y normal_z degenerate
//
// one face enters per cycle unless the pipeline is stalled; the stages are
// edges and cross product, block scaling and sum of squares, the square
// root (two root bits per stage), and the three-lane division and rounding.
// the square root and division pipelines set the depth.
// arst_n clears the valid bits only; the pipeline then starts empty.
// each stage holds its item while the next one is full and stalled.
module triangle_face_normal_top (
	input  logic                clk,
	input  logic                arst_n,
	tfn_face_if.sink            face,
	tfn_normal_if.source        result
);
	import tfn_pkg::*;

	face_t   face_d;
	cross_t  cross_d;
	sq_t     sq_d;
	len_t    len_d;
	normal_t normal_d;
	logic    cr_valid, cr_ready;
	logic    sq_valid, sq_ready;
	logic    ln_valid, ln_ready;

	assign face_d.v0_x = face.v0_x;
	assign face_d.v0_y = face.v0_y;
	assign face_d.v0_z = face.v0_z;
	assign face_d.v1_x = face.v1_x;
	assign face_d.v1_y = face.v1_y;
	assign face_d.v1_z = face.v1_z;
	assign face_d.v2_x = face.v2_x;
	assign face_d.v2_y = face.v2_y;
	assign face_d.v2_z = face.v2_z;

	tfn_cross u_cross (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (face.valid),
		.in_ready  (face.ready),
		.in_face   (face_d),
		.out_valid (cr_valid),
		.out_ready (cr_ready),
		.out_cross (cross_d)
	);

	tfn_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cr_valid),
		.in_ready  (cr_ready),
		.in_cross  (cross_d),
		.out_valid (sq_valid),
		.out_ready (sq_ready),
		.out_sq    (sq_d)
	);

	tfn_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_valid),
		.in_ready  (sq_ready),
		.in_sq     (sq_d),
		.out_valid (ln_valid),
		.out_ready (ln_ready),
		.out_len   (len_d)
	);

	tfn_divide u_divide (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (ln_valid),
		.in_ready   (ln_ready),
		.in_len     (len_d),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.out_normal (normal_d)
	);

	assign result.normal_x   = normal_d.normal_x;
	assign result.normal_y   = normal_d.normal_y;
	assign result.normal_z   = normal_d.normal_z;
	assign result.degenerate = normal_d.degenerate;
endmodule

@@ hdl/tfn_cross.sv @@
module tfn_cross (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  tfn_pkg::face_t  in_face,
	output logic            out_valid,
	input  logic            out_ready,
	output tfn_pkg::cross_t out_cross
);
	import tfn_pkg::*;

	logic signed [EDGE_W-1:0] ax_s1, ay_s1, az_s1, bx_s1, by_s1, bz_s1;
	logic signed [PROD_W-1:0] p_s2 [6];
	cross_t                   c_s3;
	logic                     vld_s1, vld_s2, vld_s3;
	logic                     en1, en2, en3;

	// stall chain, a stage loads when empty or when the next one moves
	assign en3      = !vld_s3 || out_ready;
	assign en2      = !vld_s2 || en3;
	assign en1      = !vld_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
		end
	end

	// edges a = v0 - v1, b = v1 - v2
	always_ff @(posedge clk) begin
		if (en1) begin
			ax_s1 <= EDGE_W'(in_face.v0_x) - EDGE_W'(in_face.v1_x);
			ay_s1 <= EDGE_W'(in_face.v0_y) - EDGE_W'(in_face.v1_y);
			az_s1 <= EDGE_W'(in_face.v0_z) - EDGE_W'(in_face.v1_z);
			bx_s1 <= EDGE_W'(in_face.v1_x) - EDGE_W'(in_face.v2_x);
			by_s1 <= EDGE_W'(in_face.v1_y) - EDGE_W'(in_face.v2_y);
			bz_s1 <= EDGE_W'(in_face.v1_z) - EDGE_W'(in_face.v2_z);
		end
	end

	// six partial products
	always_ff @(posedge clk) begin
		if (en2) begin
			p_s2[0] <= PROD_W'(ay_s1) * PROD_W'(bz_s1);
			p_s2[1] <= PROD_W'(az_s1) * PROD_W'(by_s1);
			p_s2[2] <= PROD_W'(az_s1) * PROD_W'(bx_s1);
			p_s2[3] <= PROD_W'(ax_s1) * PROD_W'(bz_s1);
			p_s2[4] <= PROD_W'(ax_s1) * PROD_W'(by_s1);
			p_s2[5] <= PROD_W'(ay_s1) * PROD_W'(bx_s1);
		end
	end

	// exact cross product
	always_ff @(posedge clk) begin
		if (en3) begin
			c_s3.cx <= CROSS_W'(p_s2[0]) - CROSS_W'(p_s2[1]);
			c_s3.cy <= CROSS_W'(p_s2[2]) - CROSS_W'(p_s2[3]);
			c_s3.cz <= CROSS_W'(p_s2[4]) - CROSS_W'(p_s2[5]);
		end
	end

	assign out_valid = vld_s3;
	assign out_cross = c_s3;
endmodule

@@ hdl/tfn_scale.sv @@
module tfn_scale (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  tfn_pkg::cross_t in_cross,
	output logic            out_valid,
	input  logic            out_ready,
	output tfn_pkg::sq_t    out_sq
);
	import tfn_pkg::*;

	typedef struct packed {
		logic [2:0]             neg;
		logic [2:0][MAG_W-1:0]  mag;
		logic                   degen;
	} mag_t;

	mag_t                   m_s4;
	scaled_t                sc_s5;
	scaled_t                sc_s6;
	logic [2:0][SUM_W-1:0]  sq_s6;
	sq_t                    sum_s7;
	logic                   vld_s4, vld_s5, vld_s6, vld_s7;
	logic                   en4, en5, en6, en7;
	logic [MAG_W-1:0]       orv;
	logic [SHIFT_W-1:0]     shift;
	logic signed [CROSS_W-1:0] cv [3];

	assign en7      = !vld_s7 || out_ready;
	assign en6      = !vld_s6 || en7;
	assign en5      = !vld_s5 || en6;
	assign en4      = !vld_s4 || en5;
	assign in_ready = en4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (en4) vld_s4 <= in_valid;
			if (en5) vld_s5 <= vld_s4;
			if (en6) vld_s6 <= vld_s5;
			if (en7) vld_s7 <= vld_s6;
		end
	end

	assign cv[0] = in_cross.cx;
	assign cv[1] = in_cross.cy;
	assign cv[2] = in_cross.cz;

	// sign and magnitude, zero test
	always_ff @(posedge clk) begin
		if (en4) begin
			for (int l = 0; l < 3; l++) begin
				m_s4.neg[l] <= cv[l][CROSS_W-1];
				m_s4.mag[l] <= cv[l][CROSS_W-1] ? MAG_W'(-cv[l]) : MAG_W'(cv[l]);
			end
			m_s4.degen <= (cv[0] == '0) && (cv[1] == '0) && (cv[2] == '0);
		end
	end

	// common shift from the highest set bit over all three magnitudes
	always_comb begin
		orv   = m_s4.mag[0] | m_s4.mag[1] | m_s4.mag[2];
		shift = '0;
		for (int j = 1; j <= SHIFT_MAX; j++) begin
			if (orv[SCALE_W-1+j]) shift = SHIFT_W'(j);
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			for (int l = 0; l < 3; l++) begin
				sc_s5.lane[l].neg <= m_s4.neg[l];
				sc_s5.lane[l].mag <= SCALE_W'(m_s4.mag[l] >> shift);
			end
			sc_s5.degen <= m_s4.degen;
		end
	end

	// squares
	always_ff @(posedge clk) begin
		if (en6) begin
			sc_s6 <= sc_s5;
			for (int l = 0; l < 3; l++) begin
				sq_s6[l] <= SUM_W'(sc_s5.lane[l].mag) * SUM_W'(sc_s5.lane[l].mag);
			end
		end
	end

	// sum of squares
	always_ff @(posedge clk) begin
		if (en7) begin
			sum_s7.s   <= sc_s6;
			sum_s7.sum <= sq_s6[0] + sq_s6[1] + sq_s6[2];
		end
	end

	assign out_valid = vld_s7;
	assign out_sq    = sum_s7;
endmodule

@@ hdl/tfn_isqrt.sv @@
module tfn_isqrt (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  tfn_pkg::sq_t  in_sq,
	output logic          out_valid,
	input  logic          out_ready,
	output tfn_pkg::len_t out_len
);
	import tfn_pkg::*;

	typedef struct packed {
		scaled_t           s;
		logic [SUM_W-1:0]  val;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} root_t;

	// one digit of the restoring square root, two radicand bits per digit
	function automatic root_t sqrt_step(root_t a);
		root_t            b;
		logic [REM_W-1:0] rem_n;
		logic [REM_W-1:0] trial;
		b     = a;
		rem_n = {a.rem[REM_W-3:0], a.val[SUM_W-1 -: 2]};
		trial = REM_W'({a.root, 2'b01});
		b.val = a.val << 2;
		if (rem_n >= trial) begin
			b.rem  = rem_n - trial;
			b.root = {a.root[ROOT_W-2:0], 1'b1};
		end else begin
			b.rem  = rem_n;
			b.root = {a.root[ROOT_W-2:0], 1'b0};
		end
		return b;
	endfunction

	root_t                 pipe_s [SQRT_STGS];
	logic [SQRT_STGS-1:0]  vld_s;
	logic [SQRT_STGS-1:0]  en;
	root_t                 init;

	assign init.s    = in_sq.s;
	assign init.val  = in_sq.sum;
	assign init.rem  = '0;
	assign init.root = '0;

	assign in_ready = en[0];

	for (genvar g = 0; g < SQRT_STGS; g++) begin : g_stage
		root_t src;
		root_t nxt;
		logic  vin;

		if (g == 0) begin : g_first
			assign src = init;
			assign vin = in_valid;
		end else begin : g_next
			assign src = pipe_s[g-1];
			assign vin = vld_s[g-1];
		end

		if (g == SQRT_STGS - 1) begin : g_last
			assign en[g] = !vld_s[g] || out_ready;
		end else begin : g_mid
			assign en[g] = !vld_s[g] || en[g+1];
		end

		always_comb begin
			nxt = src;
			for (int i = 0; i < SQRT_STEPS; i++) nxt = sqrt_step(nxt);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en[g]) begin
				vld_s[g] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en[g]) pipe_s[g] <= nxt;
		end
	end

	assign out_valid   = vld_s[SQRT_STGS-1];
	assign out_len.s   = pipe_s[SQRT_STGS-1].s;
	assign out_len.len = pipe_s[SQRT_STGS-1].root;
endmodule

@@ hdl/tfn_divide.sv @@
module tfn_divide (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  tfn_pkg::len_t    in_len,
	output logic             out_valid,
	input  logic             out_ready,
	output tfn_pkg::normal_t out_normal
);
	import tfn_pkg::*;

	typedef struct packed {
		scaled_t                s;
		logic [DREM_W-1:0]      len;
		logic [2:0][DREM_W-1:0] r;
		logic [2:0][Q2_W-1:0]   q;
	} div_t;

	div_t                 pipe_s [DIV_STGS];
	logic [DIV_STGS-1:0]  vld_s;
	logic [DIV_STGS-1:0]  en;
	div_t                 init;
	normal_t              res_s;
	logic                 res_vld_s;
	logic                 en_out;
	logic [Q2_W:0]        qr [3];
	logic [Q2_W:0]        qs [3];
	norm_t                nv [3];

	// first step compares the magnitude itself, later ones shift the remainder
	always_comb begin
		init.s   = in_len.s;
		init.len = (in_len.len == '0) ? DREM_W'(1) : DREM_W'(in_len.len);
		for (int l = 0; l < 3; l++) begin
			init.r[l] = DREM_W'(in_len.s.lane[l].mag);
			init.q[l] = '0;
		end
	end

	assign en_out   = !res_vld_s || out_ready;
	assign in_ready = en[0];

	for (genvar g = 0; g < DIV_STGS; g++) begin : g_stage
		div_t              src;
		div_t              nxt;
		logic              vin;
		logic [DREM_W-1:0] rs;

		if (g == 0) begin : g_first
			assign src = init;
			assign vin = in_valid;
		end else begin : g_next
			assign src = pipe_s[g-1];
			assign vin = vld_s[g-1];
		end

		if (g == DIV_STGS - 1) begin : g_last
			assign en[g] = !vld_s[g] || en_out;
		end else begin : g_mid
			assign en[g] = !vld_s[g] || en[g+1];
		end

		// restoring division, three lanes side by side
		always_comb begin
			nxt = src;
			rs  = '0;
			for (int i = 0; i < DIV_STEPS; i++) begin
				if (g * DIV_STEPS + i < Q2_W) begin
					for (int l = 0; l < 3; l++) begin
						if (g * DIV_STEPS + i == 0) rs = nxt.r[l];
						else                         rs = nxt.r[l] << 1;
						if (rs >= nxt.len) begin
							nxt.r[l] = rs - nxt.len;
							nxt.q[l] = {nxt.q[l][Q2_W-2:0], 1'b1};
						end else begin
							nxt.r[l] = rs;
							nxt.q[l] = {nxt.q[l][Q2_W-2:0], 1'b0};
						end
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en[g]) begin
				vld_s[g] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en[g]) pipe_s[g] <= nxt;
		end
	end

	// round half away, saturate, apply sign, zero a degenerate face
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			qr[l] = ({1'b0, pipe_s[DIV_STGS-1].q[l]} + (Q2_W+1)'(1)) >> 1;
			qs[l] = (qr[l] > (Q2_W+1)'(NORM_LIM)) ? (Q2_W+1)'(NORM_LIM) : qr[l];
			nv[l] = OUT_W'(qs[l]);
			if (pipe_s[DIV_STGS-1].s.lane[l].neg) nv[l] = -nv[l];
			if (pipe_s[DIV_STGS-1].s.degen) nv[l] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_s <= 1'b0;
		end else if (en_out) begin
			res_vld_s <= vld_s[DIV_STGS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			res_s.normal_x   <= nv[0];
			res_s.normal_y   <= nv[1];
			res_s.normal_z   <= nv[2];
			res_s.degenerate <= pipe_s[DIV_STGS-1].s.degen;
		end
	end

	assign out_valid  = res_vld_s;
	assign out_normal = res_s;
endmodule
